// File: rtl/scge_pkg.sv
// ----------------------------------------------------------------------------
// scge_pkg
// Mode codes, codepoints and shared types for the cell glyph encoder.
// ----------------------------------------------------------------------------
package scge_pkg;

	localparam int SAMPLES   = 8;
	localparam int CP_W      = 14;
	localparam int MAX_BYTES = 3;

	localparam logic [2:0] MODE_SINGLE  = 3'd0;
	localparam logic [2:0] MODE_HALF    = 3'd1;
	localparam logic [2:0] MODE_NARROW  = 3'd2;
	localparam logic [2:0] MODE_SHADE   = 3'd3;
	localparam logic [2:0] MODE_BRAILLE = 3'd4;
	localparam logic [2:0] MODE_LETTER  = 3'd5;
	localparam logic [2:0] MODE_BANNER  = 3'd6;
	localparam logic [2:0] MODE_BLOCK   = 3'd7;

	localparam logic [1:0] SMP_EMPTY  = 2'd0;
	localparam logic [1:0] SMP_SHADOW = 2'd1;
	localparam logic [1:0] SMP_INK    = 2'd2;

	localparam logic [CP_W-1:0] CP_SPACE        = 14'h0020;
	localparam logic [CP_W-1:0] CP_HASH         = 14'h0023;
	localparam logic [CP_W-1:0] CP_QUESTION     = 14'h003F;
	localparam logic [CP_W-1:0] CP_UPPER_HALF   = 14'h2580;
	localparam logic [CP_W-1:0] CP_LOWER_HALF   = 14'h2584;
	localparam logic [CP_W-1:0] CP_FULL         = 14'h2588;
	localparam logic [CP_W-1:0] CP_LEFT_HALF    = 14'h258C;
	localparam logic [CP_W-1:0] CP_RIGHT_HALF   = 14'h2590;
	localparam logic [CP_W-1:0] CP_LIGHT_SHADE  = 14'h2591;
	localparam logic [CP_W-1:0] CP_BRAILLE_BASE = 14'h2800;

	localparam logic [CP_W-1:0] CP_ONE_BYTE_LIM = 14'h0080;
	localparam logic [CP_W-1:0] CP_TWO_BYTE_LIM = 14'h0800;

	localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF8_CONT  = 8'h80;

	localparam logic [6:0] ASCII_FIRST = 7'd32;
	localparam logic [6:0] ASCII_LAST  = 7'd126;

	localparam logic [SAMPLES-1:0][2:0] BRAILLE_BIT = {
		3'd7, 3'd6, 3'd5, 3'd2, 3'd4, 3'd1, 3'd3, 3'd0
	};

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [1:0]                nbytes;
		logic                      shadow;
	} glyph_t;

endpackage

// File: rtl/scge_glyph.sv
// ----------------------------------------------------------------------------
// scge_glyph
// Maps one cell's samples to a codepoint and encodes it as UTF-8 bytes.
// ----------------------------------------------------------------------------
module scge_glyph #(
	parameter int LETTER_WIDTH = 8
) (
	input  logic [2:0]              mode,
	input  logic [15:0]             sub_samples,
	input  logic [63:0]             sample_letters,
	input  logic [6:0]              ink_char,
	output scge_pkg::glyph_t        glyph,
	output logic [LETTER_WIDTH-1:0] letter
);
	import scge_pkg::*;

	logic [3:0]         count;
	logic [SAMPLES-1:0] on;
	logic [SAMPLES-1:0] brl;
	logic               any_ink;
	logic               any_dim;
	logic               last_shadow;
	logic               shadow_flag;
	logic [CP_W-1:0]    cp;

	always_comb begin
		case (mode)
			MODE_HALF, MODE_NARROW, MODE_SHADE: count = 4'd2;
			MODE_BRAILLE:                       count = 4'd8;
			default:                            count = 4'd1;
		endcase
	end

	always_comb begin
		logic [1:0] v;
		on          = '0;
		brl         = '0;
		any_ink     = 1'b0;
		any_dim     = 1'b0;
		last_shadow = 1'b0;
		letter      = '0;
		for (int i = 0; i < SAMPLES; i++) begin
			v = (4'(i) < count) ? sub_samples[2*i +: 2] : SMP_EMPTY;
			on[i] = (v != SMP_EMPTY);
			if (v != SMP_EMPTY) begin
				letter      = sample_letters[8*i +: LETTER_WIDTH];
				last_shadow = (v == SMP_SHADOW);
			end
			if (v == SMP_INK)
				any_ink = 1'b1;
			if (v == SMP_SHADOW)
				any_dim = 1'b1;
		end
		for (int i = 0; i < SAMPLES; i++)
			brl[BRAILLE_BIT[i]] = on[i];
	end

	always_comb begin
		shadow_flag = last_shadow;
		case (mode)
			MODE_HALF, MODE_SHADE: begin
				case (on[1:0])
					2'b00:   cp = CP_SPACE;
					2'b01:   cp = CP_UPPER_HALF;
					2'b10:   cp = CP_LOWER_HALF;
					default: cp = CP_FULL;
				endcase
			end
			MODE_NARROW: begin
				case (on[1:0])
					2'b00:   cp = CP_SPACE;
					2'b01:   cp = CP_LEFT_HALF;
					2'b10:   cp = CP_RIGHT_HALF;
					default: cp = CP_FULL;
				endcase
			end
			MODE_BRAILLE: cp = CP_BRAILLE_BASE | {{(CP_W-SAMPLES){1'b0}}, brl};
			MODE_LETTER: begin
				if (!on[0])
					cp = CP_SPACE;
				else if (ink_char < ASCII_FIRST || ink_char > ASCII_LAST)
					cp = CP_QUESTION;
				else
					cp = {{(CP_W-7){1'b0}}, ink_char};
			end
			MODE_BANNER: cp = on[0] ? CP_HASH : CP_SPACE;
			MODE_BLOCK: begin
				if (any_ink) begin
					cp = CP_FULL;
				end else if (any_dim) begin
					cp = CP_LIGHT_SHADE;
					shadow_flag = 1'b1;
				end else begin
					cp = CP_SPACE;
				end
			end
			default: cp = on[0] ? CP_FULL : CP_SPACE;
		endcase
	end

	always_comb begin
		glyph.bytes  = '0;
		glyph.shadow = shadow_flag;
		if (cp < CP_ONE_BYTE_LIM) begin
			glyph.bytes[0] = cp[7:0];
			glyph.nbytes   = 2'd1;
		end else if (cp < CP_TWO_BYTE_LIM) begin
			glyph.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
			glyph.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
			glyph.nbytes   = 2'd2;
		end else begin
			glyph.bytes[0] = UTF8_LEAD3 | {6'b000000, cp[13:12]};
			glyph.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
			glyph.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
			glyph.nbytes   = 2'd3;
		end
	end

endmodule

// File: rtl/subpixel_cell_glyph_encoder_unit.sv
// ----------------------------------------------------------------------------
// subpixel_cell_glyph_encoder_unit
// Terminal cell to UTF-8 glyph encoder with a byte-serial result channel.
// ----------------------------------------------------------------------------
// An accepted cell goes through the input register and then the glyph register
// before its first byte is presented. The one-byte result port emits a cell's
// UTF-8 bytes one after another, and out_stall holds them.
// The next cell is taken into the input register while bytes still drain.
// Reset: arst_n clears the mode register to single and empties both stages.
module subpixel_cell_glyph_encoder_unit #(
	parameter int LETTER_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cell_mode,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] sub_samples,
	input  logic [63:0] sample_letters,
	input  logic [6:0]  ink_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  utf8_byte,
	output logic        last_byte,
	output logic [7:0]  cell_letter,
	output logic        cell_shadow
);
	import scge_pkg::*;

	logic [2:0]              mode_q;
	logic                    valid_s1;
	logic [15:0]             samples_s1;
	logic [63:0]             letters_s1;
	logic [6:0]              ink_s1;
	glyph_t                  glyph;
	logic [LETTER_WIDTH-1:0] letter;
	logic                    valid_s2;
	glyph_t                  glyph_s2;
	logic [LETTER_WIDTH-1:0] letter_s2;
	logic [1:0]              idx_q;
	logic                    out_fire;
	logic                    out_done;
	logic                    load_s2;
	logic                    in_fire;

	assign out_fire = valid_s2 && !out_stall;
	assign out_done = out_fire && last_byte;
	assign load_s2  = valid_s1 && (!valid_s2 || out_done);
	assign in_stall = valid_s1 && !load_s2;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SINGLE;
		end else if (cfg_wr_en) begin
			mode_q <= cell_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			samples_s1 <= sub_samples;
			letters_s1 <= sample_letters;
			ink_s1     <= ink_char;
		end
	end

	scge_glyph #(
		.LETTER_WIDTH(LETTER_WIDTH)
	) u_glyph (
		.mode          (mode_q),
		.sub_samples   (samples_s1),
		.sample_letters(letters_s1),
		.ink_char      (ink_s1),
		.glyph         (glyph),
		.letter        (letter)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
			idx_q    <= 2'd0;
		end else if (out_done) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (out_fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			glyph_s2  <= glyph;
			letter_s2 <= letter;
		end
	end

	assign out_valid   = valid_s2;
	assign utf8_byte   = (idx_q == 2'd0) ? glyph_s2.bytes[0] :
	                     (idx_q == 2'd1) ? glyph_s2.bytes[1] : glyph_s2.bytes[2];
	assign last_byte   = (idx_q == (glyph_s2.nbytes - 2'd1));
	assign cell_letter = 8'(letter_s2);
	assign cell_shadow = glyph_s2.shadow;

endmodule
